// ----- hw/rtl/adc_sample_averaging_engine_defines.svh -----
// Assertion macros shared by the checker files of the averaging engine.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef ADC_SAMPLE_AVERAGING_ENGINE_DEFINES_SVH
`define ADC_SAMPLE_AVERAGING_ENGINE_DEFINES_SVH

// Implication in the same cycle.
`define ASAE_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication in the next cycle.
`define ASAE_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/asae_pkg.sv -----
`default_nettype none
package asae_pkg;

	localparam int LOG2_SAMPLES = 5;
	localparam int SAMPLE_BITS  = 16;
	localparam int SUM_W        = SAMPLE_BITS + LOG2_SAMPLES;
	localparam int CNT_W        = LOG2_SAMPLES + 1;
	localparam int AVG_W        = 16;

	localparam logic [CNT_W-1:0] NUM_SAMPLES = CNT_W'(1) << LOG2_SAMPLES;

	localparam logic [7:0] INTERVAL_RESET = 8'd16;

	// Register indexes on the host bus.
	localparam logic [7:0] REG_CTRL    = 8'd0;
	localparam logic [7:0] REG_AVG_MSB = 8'd1;
	localparam logic [7:0] REG_AVG_LSB = 8'd2;

	// Control byte bit positions.
	localparam int CTL_START_BIT = 0;
	localparam int CTL_BUSY_BIT  = 1;

	typedef enum logic [2:0] {
		OP_WRITE  = 3'd0,
		OP_READ   = 3'd1,
		OP_XEND   = 3'd2,
		OP_TICK   = 3'd3,
		OP_SAMPLE = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_WAIT   = 2'd1,
		PH_SAMPLE = 2'd2
	} phase_t;

	typedef struct packed {
		logic [2:0]  op;
		logic [7:0]  reg_addr;
		logic [7:0]  write_data;
		logic [15:0] sample_value;
	} cmd_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       start_conversion;
		logic [5:0] conv_channel;
		logic       busy_res;
	} rsp_t;

endpackage
`default_nettype wire

// ----- hw/rtl/asae_if.sv -----
`default_nettype none

interface asae_cmd_if import asae_pkg::*; ();
	logic valid;
	logic ready;
	cmd_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface asae_rsp_if import asae_pkg::*; ();
	logic valid;
	logic ready;
	rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface asae_cfg_if ();
	logic       valid;
	logic       ready;
	logic [7:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/adc_sample_averaging_engine.sv -----
// ADC averaging engine: takes one request per cycle (register write, register read,
// transaction end, timer tick or completed sample) and returns exactly one result for
// each, in the cycle after the request is taken, from a single output register. Requests
// stall only while that register holds a result the sink has not taken. A run started
// by the start bit asks for 32 conversions, waits the programmed number of ticks (at
// least one) between them and stores the 16-bit average, readable as two bytes; the
// interval register may be written at any time the engine is idle and resets to 16.
`default_nettype none
module adc_sample_averaging_engine
	import asae_pkg::*;
(
	input wire logic     clk,
	input wire logic     arst_n,
	asae_cmd_if.sink     cmd,
	asae_rsp_if.source   rsp,
	asae_cfg_if.sink     cfg
);

	logic [7:0]       interval_q;
	logic [7:0]       ctrl_q, ctrl_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [SUM_W-1:0] sum_q, sum_d;
	logic [AVG_W-1:0] avg_q, avg_d;
	logic [7:0]       ticks_q, ticks_d;
	phase_t           phase_q, phase_d;
	logic             rsp_valid_q;
	rsp_t             rsp_q, rsp_d;

	logic             take;
	logic             run_start;
	logic             tick_fire;
	logic             sample_take;
	logic             last_sample;
	logic [SUM_W-1:0] sum_add;
	logic [CNT_W-1:0] count_inc;

	assign cmd.ready = !rsp_valid_q || rsp.ready;
	assign take      = cmd.valid && cmd.ready;
	assign cfg.ready = 1'b1;
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

	assign sum_add   = sum_q + SUM_W'(cmd.data.sample_value[SAMPLE_BITS-1:0]);
	assign count_inc = count_q + CNT_W'(1);

	assign run_start   = (cmd.data.op == OP_XEND) && ctrl_q[CTL_START_BIT];
	assign tick_fire   = (cmd.data.op == OP_TICK) && (phase_q == PH_WAIT) && (ticks_q <= 8'd1);
	assign sample_take = (cmd.data.op == OP_SAMPLE) && (phase_q == PH_SAMPLE);
	assign last_sample = count_inc >= NUM_SAMPLES;

	// Sequencer next state.
	always_comb begin
		phase_d = phase_q;
		if (run_start) begin
			phase_d = PH_SAMPLE;
		end else if (tick_fire) begin
			phase_d = PH_SAMPLE;
		end else if (sample_take) begin
			phase_d = last_sample ? PH_IDLE : PH_WAIT;
		end
	end

	// Datapath and result for the request on the input channel.
	always_comb begin
		ctrl_d  = ctrl_q;
		count_d = count_q;
		sum_d   = sum_q;
		avg_d   = avg_q;
		ticks_d = ticks_q;
		rsp_d   = '0;
		unique case (cmd.data.op)
			OP_WRITE: begin
				if (cmd.data.reg_addr == REG_CTRL) begin
					ctrl_d = cmd.data.write_data;
				end
			end
			OP_READ: begin
				priority if (cmd.data.reg_addr == REG_CTRL) begin
					rsp_d.read_data = ctrl_q;
				end else if (cmd.data.reg_addr == REG_AVG_MSB) begin
					rsp_d.read_data = avg_q[15:8];
				end else if (cmd.data.reg_addr == REG_AVG_LSB) begin
					rsp_d.read_data = avg_q[7:0];
				end else begin
					rsp_d.read_data = 8'd0;
				end
			end
			OP_XEND: begin
				if (run_start) begin
					ctrl_d[CTL_START_BIT] = 1'b0;
					ctrl_d[CTL_BUSY_BIT]  = 1'b1;
					count_d = '0;
					sum_d   = '0;
					avg_d   = '0;
				end
			end
			OP_TICK: begin
				if (phase_q == PH_WAIT) begin
					ticks_d = tick_fire ? 8'd0 : ticks_q - 8'd1;
				end
			end
			OP_SAMPLE: begin
				if (sample_take) begin
					sum_d   = sum_add;
					count_d = count_inc;
					if (last_sample) begin
						avg_d = AVG_W'(sum_add >> LOG2_SAMPLES);
						ctrl_d[CTL_BUSY_BIT] = 1'b0;
					end else begin
						ticks_d = interval_q;
					end
				end
			end
			default: begin
			end
		endcase
		rsp_d.start_conversion = run_start || tick_fire;
		rsp_d.conv_channel     = ctrl_d[7:2];
		rsp_d.busy_res         = ctrl_d[CTL_BUSY_BIT];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q  <= INTERVAL_RESET;
			ctrl_q      <= '0;
			count_q     <= '0;
			sum_q       <= '0;
			avg_q       <= '0;
			ticks_q     <= '0;
			phase_q     <= PH_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				interval_q <= cfg.data;
			end
			if (take) begin
				ctrl_q  <= ctrl_d;
				count_q <= count_d;
				sum_q   <= sum_d;
				avg_q   <= avg_d;
				ticks_q <= ticks_d;
				phase_q <= phase_d;
			end
			if (take) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			rsp_q <= rsp_d;
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/asae_checker.sv -----
`default_nettype none
`include "adc_sample_averaging_engine_defines.svh"

module asae_checker
	import asae_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cmd_valid,
	input wire logic cmd_ready,
	input wire cmd_t cmd_data,
	input wire logic rsp_valid,
	input wire logic rsp_ready,
	input wire rsp_t rsp_data
);

	// Every request taken produces a result in the following cycle.
	`ASAE_ASSERT_NEXT(a_rsp_follows, cmd_valid && cmd_ready, rsp_valid, "request lost")

	// A result still held back blocks new requests.
	`ASAE_ASSERT_NOW(a_backpressure, rsp_valid && !rsp_ready, !cmd_ready, "request taken while result stalled")

	// Only register reads return non-zero read data.
	`ASAE_ASSERT_NEXT(a_rdata_zero, cmd_valid && cmd_ready && (cmd_data.op != OP_READ), rsp_data.read_data == 8'd0, "read data on a non-read request")

	// A stalled result keeps its payload.
	`ASAE_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "stalled result changed")

endmodule

bind adc_sample_averaging_engine asae_checker u_asae_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd.valid),
	.cmd_ready (cmd.ready),
	.cmd_data  (cmd.data),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);

`default_nettype wire

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps

module tb;
	import asae_pkg::*;

	// Op codes that the engine must treat as a plain non-read.
	localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
	localparam logic [2:0] OP_SPARE_LAST  = 3'd7;
	localparam logic [7:0] REG_UNKNOWN    = 8'hFF;

	typedef enum logic [1:0] {
		GAPS_RX_HEAVY,
		GAPS_TX_HEAVY,
		GAPS_NONE
	} gap_mode_t;

	typedef enum logic [1:0] {
		FILL_RANDOM,
		FILL_MAX,
		FILL_ZERO
	} sample_fill_t;

	logic clk;
	logic arst_n;

	asae_cmd_if cmd_bus ();
	asae_rsp_if rsp_bus ();
	asae_cfg_if cfg_bus ();

	adc_sample_averaging_engine DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_bus),
		.rsp    (rsp_bus),
		.cfg    (cfg_bus)
	);

	cmd_t      bus_requests[$];
	rsp_t      awaited_results[$];
	gap_mode_t gap_mode;
	int        mismatches;
	int        section_items;
	logic [7:0] gap_ticks;
	bit        cmd_taken;

	// Predicted engine state.
	logic [7:0]       ctl_byte;
	logic [CNT_W-1:0] samples_taken;
	logic [SUM_W-1:0] sum_acc;
	logic [AVG_W-1:0] avg_word;
	phase_t           eng_phase;
	logic [7:0]       ticks_left;
	logic [7:0]       interval_ticks;

	always #5 clk = ~clk;

	function automatic bit roll(int pct);
		return int'($urandom_range(99, 0)) < pct;
	endfunction

	function automatic logic [7:0] rand_byte();
		return 8'($urandom_range(255, 0));
	endfunction

	function automatic logic [15:0] rand_word();
		return 16'($urandom_range(65535, 0));
	endfunction

	function automatic rsp_t step_engine(cmd_t c);
		rsp_t r;
		r = '0;
		case (c.op)
		OP_WRITE: begin
			if (c.reg_addr == REG_CTRL)
				ctl_byte = c.write_data;
		end
		OP_READ: begin
			case (c.reg_addr)
			REG_CTRL:    r.read_data = ctl_byte;
			REG_AVG_MSB: r.read_data = avg_word[15:8];
			REG_AVG_LSB: r.read_data = avg_word[7:0];
			default:     r.read_data = '0;
			endcase
		end
		OP_XEND: begin
			// The start bit restarts the run even when one is in progress.
			if (ctl_byte[CTL_START_BIT]) begin
				ctl_byte[CTL_START_BIT] = 1'b0;
				ctl_byte[CTL_BUSY_BIT] = 1'b1;
				samples_taken = '0;
				sum_acc = '0;
				avg_word = '0;
				eng_phase = PH_SAMPLE;
				r.start_conversion = 1'b1;
			end
		end
		OP_TICK: begin
			if (eng_phase == PH_WAIT) begin
				// An interval of zero expires on the first tick, as one does.
				if (ticks_left <= 8'd1) begin
					ticks_left = '0;
					eng_phase = PH_SAMPLE;
					r.start_conversion = 1'b1;
				end else begin
					ticks_left = ticks_left - 8'd1;
				end
			end
		end
		OP_SAMPLE: begin
			if (eng_phase == PH_SAMPLE) begin
				sum_acc = sum_acc + SUM_W'(c.sample_value[SAMPLE_BITS-1:0]);
				samples_taken = samples_taken + CNT_W'(1);
				if (samples_taken >= NUM_SAMPLES) begin
					avg_word = AVG_W'(sum_acc >> LOG2_SAMPLES);
					ctl_byte[CTL_BUSY_BIT] = 1'b0;
					eng_phase = PH_IDLE;
				end else begin
					ticks_left = interval_ticks;
					eng_phase = PH_WAIT;
				end
			end
		end
		default: begin
		end
		endcase
		r.conv_channel = ctl_byte[7:2];
		r.busy_res = ctl_byte[CTL_BUSY_BIT];
		return r;
	endfunction

	function automatic bit sender_gap();
		case (gap_mode)
		GAPS_RX_HEAVY: return roll(25);
		GAPS_TX_HEAVY: return roll(65);
		default:       return 1'b0;
		endcase
	endfunction

	function automatic bit receiver_gap();
		case (gap_mode)
		GAPS_RX_HEAVY: return roll(65);
		GAPS_TX_HEAVY: return roll(25);
		default:       return 1'b0;
		endcase
	endfunction

	// Driver: presents queued requests and drives the result ready.
	always @(negedge clk) begin
		if (!arst_n) begin
			cmd_bus.valid <= 1'b0;
			rsp_bus.ready <= 1'b0;
		end else begin
			if (!cmd_bus.valid || cmd_taken) begin
				if (bus_requests.size() != 0 && !sender_gap()) begin
					cmd_bus.data <= bus_requests.pop_front();
					cmd_bus.valid <= 1'b1;
				end else begin
					cmd_bus.valid <= 1'b0;
				end
			end
			rsp_bus.ready <= !receiver_gap();
		end
	end

	// Monitor: checks results against the oldest prediction, then predicts new requests.
	always @(posedge clk) begin
		rsp_t want;
		rsp_t got;
		if (arst_n) begin
			if (rsp_bus.valid && rsp_bus.ready) begin
				got = rsp_bus.data;
				if (awaited_results.size() == 0) begin
					$display("%0t: unexpected result read_data=%h start=%b channel=%h busy=%b",
						$time, got.read_data, got.start_conversion, got.conv_channel,
						got.busy_res);
					mismatches++;
				end else begin
					want = awaited_results.pop_front();
					if (got.read_data !== want.read_data
							|| got.start_conversion !== want.start_conversion
							|| got.conv_channel !== want.conv_channel
							|| got.busy_res !== want.busy_res) begin
						$display({"%0t: result mismatch: expected read_data=%h start=%b ",
							"channel=%h busy=%b, got read_data=%h start=%b channel=%h busy=%b"},
							$time, want.read_data, want.start_conversion, want.conv_channel,
							want.busy_res, got.read_data, got.start_conversion,
							got.conv_channel, got.busy_res);
						mismatches++;
					end
				end
			end
			if (cmd_bus.valid && cmd_bus.ready)
				awaited_results.push_back(step_engine(cmd_bus.data));
			if (cfg_bus.valid && cfg_bus.ready)
				interval_ticks = cfg_bus.data;
			cmd_taken = cmd_bus.valid && cmd_bus.ready;
		end
	end

	task automatic push_req(logic [2:0] op, logic [7:0] addr, logic [7:0] wdata,
			logic [15:0] smp);
		cmd_t c;
		c.op = op;
		c.reg_addr = addr;
		c.write_data = wdata;
		c.sample_value = smp;
		bus_requests.push_back(c);
		section_items++;
	endtask

	task automatic add_noise();
		logic [7:0] addr;
		addr = roll(50) ? 8'($urandom_range(3, 0)) : rand_byte();
		push_req(3'($urandom_range(OP_SPARE_LAST, 0)), addr, rand_byte(), rand_word());
	endtask

	// One measurement run: program channel and start, end the transaction, alternate
	// completed samples with the ticks of the interval, then read back the registers.
	task automatic queue_run(int n_samples, sample_fill_t fill);
		logic [7:0]  ctl;
		logic [15:0] value;
		int          gap;
		ctl = rand_byte();
		ctl[CTL_START_BIT] = 1'b1;
		push_req(OP_WRITE, REG_CTRL, ctl, rand_word());
		push_req(OP_XEND, rand_byte(), rand_byte(), rand_word());
		for (int i = 0; i < n_samples; i++) begin
			if (roll(8))
				add_noise();
			case (fill)
			FILL_MAX:  value = '1;
			FILL_ZERO: value = '0;
			default:   value = roll(15) ? (roll(50) ? 16'hFFFF : 16'h0000)
					: rand_word();
			endcase
			push_req(OP_SAMPLE, rand_byte(), rand_byte(), value);
			if (i < n_samples - 1) begin
				gap = (gap_ticks == 8'd0) ? 1 : int'(gap_ticks);
				if (roll(10))
					gap += int'($urandom_range(3, 1));
				if (roll(4)) begin
					// Move to another channel in the middle of the run.
					ctl = rand_byte();
					ctl[CTL_START_BIT] = 1'b0;
					ctl[CTL_BUSY_BIT] = 1'b1;
					push_req(OP_WRITE, REG_CTRL, ctl, rand_word());
				end
				repeat (gap) begin
					if (roll(8))
						add_noise();
					push_req(OP_TICK, rand_byte(), rand_byte(), rand_word());
				end
			end
		end
		push_req(OP_READ, REG_CTRL, rand_byte(), rand_word());
		push_req(OP_READ, REG_AVG_MSB, rand_byte(), rand_word());
		push_req(OP_READ, REG_AVG_LSB, rand_byte(), rand_word());
	endtask

	task automatic run_section(int budget);
		section_items = 0;
		while (section_items < budget)
			queue_run(roll(75) ? 32 : int'($urandom_range(31, 1)), FILL_RANDOM);
	endtask

	task automatic drain();
		while (bus_requests.size() != 0 || cmd_bus.valid || awaited_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic program_interval(logic [7:0] value);
		drain();
		gap_ticks = value;
		@(negedge clk);
		cfg_bus.data <= value;
		cfg_bus.valid <= 1'b1;
		@(posedge clk);
		while (!(cfg_bus.valid && cfg_bus.ready))
			@(posedge clk);
		@(negedge clk);
		cfg_bus.valid <= 1'b0;
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cmd_bus.valid = 1'b0;
		cmd_bus.data = '0;
		rsp_bus.ready = 1'b0;
		cfg_bus.valid = 1'b0;
		cfg_bus.data = '0;
		mismatches = 0;
		cmd_taken = 1'b0;
		gap_mode = GAPS_RX_HEAVY;
		gap_ticks = INTERVAL_RESET;
		ctl_byte = '0;
		samples_taken = '0;
		sum_acc = '0;
		avg_word = '0;
		eng_phase = PH_IDLE;
		ticks_left = '0;
		interval_ticks = INTERVAL_RESET;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed requests at the reset interval.
		push_req(OP_READ, REG_CTRL, 8'h00, 16'h0000);
		push_req(OP_READ, REG_AVG_MSB, 8'hFF, 16'hFFFF);
		push_req(OP_READ, REG_AVG_LSB, 8'h00, 16'h0000);
		push_req(OP_READ, REG_UNKNOWN, 8'hFF, 16'hFFFF);
		push_req(OP_XEND, REG_CTRL, 8'hFF, 16'hFFFF);
		push_req(OP_TICK, REG_CTRL, 8'h00, 16'h0000);
		push_req(OP_SAMPLE, REG_UNKNOWN, 8'hFF, 16'hFFFF);
		push_req(OP_SPARE_FIRST, REG_CTRL, 8'hFF, 16'hFFFF);
		push_req(OP_SPARE_FIRST + 3'd1, REG_UNKNOWN, 8'h00, 16'h0000);
		push_req(OP_SPARE_LAST, REG_UNKNOWN, 8'hFF, 16'hFFFF);
		push_req(OP_WRITE, REG_UNKNOWN, 8'hFF, 16'h0000);
		push_req(OP_WRITE, REG_CTRL, 8'hFF, 16'h0000);
		push_req(OP_READ, REG_CTRL, 8'h00, 16'h0000);
		push_req(OP_XEND, REG_CTRL, 8'h00, 16'h0000);
		push_req(OP_SAMPLE, REG_CTRL, 8'h00, 16'hFFFF);
		push_req(OP_TICK, REG_CTRL, 8'h00, 16'h0000);
		push_req(OP_WRITE, REG_CTRL, 8'h01, 16'h0000);
		push_req(OP_XEND, REG_CTRL, 8'h00, 16'h0000);
		push_req(OP_SAMPLE, REG_CTRL, 8'h00, 16'h0000);
		push_req(OP_TICK, REG_CTRL, 8'h00, 16'h0000);
		push_req(OP_READ, REG_CTRL, 8'h00, 16'h0000);
		push_req(OP_WRITE, REG_CTRL, 8'h00, 16'h0000);

		program_interval(8'd1);
		section_items = 0;
		queue_run(32, FILL_MAX);
		queue_run(32, FILL_ZERO);
		run_section(250);

		program_interval(8'd0);
		run_section(200);

		gap_mode = GAPS_TX_HEAVY;
		program_interval(8'd255);
		queue_run(2, FILL_RANDOM);
		queue_run(2, FILL_RANDOM);

		program_interval(8'($urandom_range(4, 2)));
		run_section(250);

		gap_mode = GAPS_NONE;
		program_interval(8'($urandom_range(6, 1)));
		run_section(250);

		drain();
		repeat (4) @(posedge clk);
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#2000000;
		$display("Some tests failed");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/asae_pkg.sv
hw/rtl/asae_if.sv
hw/rtl/adc_sample_averaging_engine.sv
hw/rtl/asae_checker.sv
tb/sv/tb.sv
